// ===== rtl/core/prs80_pkg.sv =====
// ============================================================================
// prs80_pkg: shared types, constants and round functions
// Bit-level building blocks of the PRESENT-80 cipher: S-box, nibble
// substitution layer, bit permutation layer and key schedule step.
// ============================================================================
package prs80_pkg;

    localparam int unsigned BLOCK_W    = 64;
    localparam int unsigned KEY_W      = 80;
    localparam int unsigned KEY_LO_W   = 64;
    localparam int unsigned KEY_HI_W   = 16;
    localparam int unsigned NUM_ROUNDS = 31;
    // stage 0 is the input register, stages 1..31 the rounds, 32 the output
    localparam int unsigned LAST_STAGE = NUM_ROUNDS + 1;
    localparam int unsigned RC_W       = 5;
    localparam int unsigned CFG_IDX_W  = 1;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [RC_W-1:0]    t_rc;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

    // 4-bit S-box
    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        unique case (x)
            4'h0: y = 4'hc;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hb;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'ha;
            4'h7: y = 4'hd;
            4'h8: y = 4'h3;
            4'h9: y = 4'he;
            4'ha: y = 4'hf;
            4'hb: y = 4'h8;
            4'hc: y = 4'h4;
            4'hd: y = 4'h7;
            4'he: y = 4'h1;
            4'hf: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    // S-box on all 16 nibbles
    function automatic t_block sub_layer(input t_block s);
        t_block r;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

    // bit b moves to 16*b mod 63, bit 63 stays put (pure wiring)
    function automatic t_block perm_layer(input t_block s);
        t_block r;
        for (int b = 0; b < BLOCK_W - 1; b++) begin
            r[(16 * b) % (BLOCK_W - 1)] = s[b];
        end
        r[BLOCK_W-1] = s[BLOCK_W-1];
        return r;
    endfunction

    // round key is the top 64 key bits
    function automatic t_block round_key(input t_key k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

    // rotate left by 61, S-box on top nibble, round counter into bits 19..15
    function automatic t_key key_update(input t_key k, input t_rc rc);
        t_key r;
        r = {k[18:0], k[KEY_W-1:19]};
        r[KEY_W-1 -: 4] = sbox(r[KEY_W-1 -: 4]);
        r[19:15] = r[19:15] ^ rc;
        return r;
    endfunction

endpackage

// ===== rtl/core/present80_block_encrypt_top.sv =====
// ============================================================================
// present80_block_encrypt_top: PRESENT-80 block encryption pipeline
// Fully unrolled 31-round cipher, one register stage per round, with the
// key schedule carried down the pipeline next to each block.
// ============================================================================
// Encrypts 64-bit blocks with PRESENT under the 80-bit key held in
// key_low (index 0) and key_high (index 1). One block is taken per clock
// while the output is not stalled, and each ciphertext passes through an
// input register, one register stage per round (31) and an output stage
// that adds the final round key. Each stage holds its own valid bit and
// advances whenever the stage after it is empty or moving, so bubbles
// collapse and a stalled output backs the pipeline up without loss.
// Write the key only while no block is in flight.
module present80_block_encrypt_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [prs80_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [prs80_pkg::KEY_LO_W-1:0]      i_cfg_wdata,
    // plaintext stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [prs80_pkg::BLOCK_W-1:0]       i_s_tdata,   // [63:0] plaintext
    // ciphertext stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [prs80_pkg::BLOCK_W-1:0]       o_m_tdata    // [63:0] ciphertext
);
    import prs80_pkg::*;

    // key registers
    logic [KEY_LO_W-1:0] r_key_low;
    logic [KEY_HI_W-1:0] r_key_high;

    // pipeline registers
    logic [LAST_STAGE:0] r_valid;
    t_block              r_state [0:LAST_STAGE];
    t_key                r_key   [0:NUM_ROUNDS];

    // next values and per-stage load enables
    t_block              n_state [1:LAST_STAGE];
    t_key                n_key   [1:NUM_ROUNDS];
    logic [LAST_STAGE:0] w_load;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_wdata;
                CFG_KEY_HIGH: r_key_high <= i_cfg_wdata[KEY_HI_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_load[LAST_STAGE] = !r_valid[LAST_STAGE] || i_m_tready;
        for (int k = LAST_STAGE - 1; k >= 0; k--) begin
            w_load[k] = !r_valid[k] || w_load[k+1];
        end
    end

    // one round per stage, final key addition in the output stage
    always_comb begin
        for (int k = 1; k <= NUM_ROUNDS; k++) begin
            n_state[k] = perm_layer(sub_layer(r_state[k-1] ^ round_key(r_key[k-1])));
            n_key[k]   = key_update(r_key[k-1], RC_W'(k));
        end
        n_state[LAST_STAGE] = r_state[NUM_ROUNDS] ^ round_key(r_key[NUM_ROUNDS]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_load[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int k = 1; k <= LAST_STAGE; k++) begin
                if (w_load[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_load[0]) begin
            r_state[0] <= i_s_tdata;
            r_key[0]   <= {r_key_high, r_key_low};
        end
        for (int k = 1; k <= NUM_ROUNDS; k++) begin
            if (w_load[k]) begin
                r_state[k] <= n_state[k];
                r_key[k]   <= n_key[k];
            end
        end
        if (w_load[LAST_STAGE]) begin
            r_state[LAST_STAGE] <= n_state[LAST_STAGE];
        end
    end

    assign o_s_tready = w_load[0];
    assign o_m_tvalid = r_valid[LAST_STAGE];
    assign o_m_tdata  = r_state[LAST_STAGE];

`ifndef SYNTH
    // occupancy tracks transactions in and out
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_valid) == $past($countones(r_valid))
            + int'($past(i_s_tvalid && o_s_tready))
            - int'($past(o_m_tvalid && i_m_tready)))
        else $error("pipeline occupancy mismatch");

    // an accepted block lands in the input stage
    a_input_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_valid[0])
        else $error("accepted block not captured");

    // an empty input stage always accepts
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valid[0] |-> o_s_tready)
        else $error("input stage empty but not ready");

    // the pipeline is empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_valid == '0)
        else $error("valid bits not cleared by reset");
`endif

endmodule

// ===== tb/tb_present80_block_encrypt_top.sv =====
// ============================================================================
// tb_present80_block_encrypt_top: PRESENT-80 encryption pipeline testbench
// Streams plaintext blocks through the cipher under a sequence of keys and
// checks every ciphertext against a bit-exact encryption model kept in the
// bench. Both stream sides idle at random, and keys change between phases
// while the pipeline is empty.
// ============================================================================
module tb_present80_block_encrypt_top;
    import prs80_pkg::*;

    // input register, 31 rounds, output stage
    localparam int unsigned PIPE_DEPTH = LAST_STAGE + 1;
    localparam int unsigned SETTLE_CYC = PIPE_DEPTH + 8;
    // S-box output for nibble value i sits in bits 4*i+3..4*i
    localparam logic [63:0] NIBBLE_SUB = 64'h2174_8FE3_DA09_B65C;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_KEY_LOW;
    logic [KEY_LO_W-1:0]  cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    t_block               s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    t_block               m_tdata;

    t_block               plain_pending_q[$];
    t_block               cipher_expect_q[$];
    logic [KEY_LO_W-1:0]  key_lo_cur = '0;
    logic [KEY_HI_W-1:0]  key_hi_cur = '0;
    int unsigned          mismatch_cnt = 0;

    present80_block_encrypt_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Encryption model
    // ------------------------------------------------------------------
    function automatic t_block nibble_subst(input t_block v);
        t_block r;
        int     idx;
        for (int n = 0; n < 16; n++) begin
            idx = v[4*n +: 4];
            r[4*n +: 4] = NIBBLE_SUB[4*idx +: 4];
        end
        return r;
    endfunction

    // destination d takes source 4*d mod 63 (4 is the inverse of 16 mod 63)
    function automatic t_block bit_scatter(input t_block v);
        t_block r;
        for (int d = 0; d < 63; d++) begin
            r[d] = v[(4 * d) % 63];
        end
        r[63] = v[63];
        return r;
    endfunction

    function automatic t_block present_encrypt(input t_block pt,
                                               input logic [KEY_LO_W-1:0] klo,
                                               input logic [KEY_HI_W-1:0] khi);
        t_block     st;
        t_key       k;
        int         top;
        st = pt;
        k  = {khi, klo};
        for (int rnd = 1; rnd <= NUM_ROUNDS; rnd++) begin
            st = bit_scatter(nibble_subst(st ^ k[79:16]));
            // key register: rotate left 61, S-box top nibble, add counter
            k = {k[18:0], k[79:19]};
            top = k[79:76];
            k[79:76] = NIBBLE_SUB[4*top +: 4];
            k[19:15] = k[19:15] ^ t_rc'(rnd);
        end
        return st ^ k[79:16];
    endfunction

    // per-transaction wait of random length, with occasional runs of no idling
    task automatic pick_wait(inout int unsigned burst, output int unsigned gap);
        if (burst != 0) begin
            burst--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 3);
            if ($urandom_range(0, 31) == 0)
                burst = $urandom_range(8, 40);
        end
    endtask

    // ------------------------------------------------------------------
    // Plaintext driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : plain_drv
        int unsigned src_gap;
        int unsigned src_burst;
        if (!i_rst_n) begin
            s_tvalid  <= 1'b0;
            src_gap   = 0;
            src_burst = 0;
        end else begin
            // accepted transaction: predict its ciphertext under the current key
            if (s_tvalid && s_tready)
                cipher_expect_q.push_back(present_encrypt(s_tdata, key_lo_cur, key_hi_cur));
            if (!s_tvalid || s_tready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end else if (plain_pending_q.size() != 0) begin
                    s_tdata  <= plain_pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    pick_wait(src_burst, src_gap);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Ciphertext monitor and checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : cipher_mon
        int unsigned snk_stall;
        int unsigned snk_burst;
        t_block      want;
        if (!i_rst_n) begin
            m_tready  <= 1'b0;
            snk_stall = 0;
            snk_burst = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (cipher_expect_q.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected ciphertext: expected none, actual %h",
                             $time, m_tdata);
                end else begin
                    want = cipher_expect_q.pop_front();
                    if (m_tdata !== want) begin
                        mismatch_cnt++;
                        $display("%0t: ciphertext mismatch: expected %h, actual %h",
                                 $time, want, m_tdata);
                    end
                end
                pick_wait(snk_burst, snk_stall);
            end
            if (snk_stall != 0) begin
                snk_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [KEY_LO_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_KEY_LOW)
            key_lo_cur = val;
        else
            key_hi_cur = val[KEY_HI_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // random blocks, some sparse or dense single-bit patterns
    task automatic queue_random(input int unsigned count);
        t_block pt;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(0, 7))
                0:       pt = t_block'(1) << $urandom_range(0, 63);
                1:       pt = ~(t_block'(1) << $urandom_range(0, 63));
                default: pt = {$urandom, $urandom};
            endcase
            plain_pending_q.push_back(pt);
        end
    endtask

    // wait until every block has come back, then let the pipeline settle
    task automatic drain_pipeline();
        while (plain_pending_q.size() != 0 || s_tvalid || cipher_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key (all zero)
        plain_pending_q.push_back('0);
        plain_pending_q.push_back('1);
        plain_pending_q.push_back({16{4'h5}});
        plain_pending_q.push_back({16{4'ha}});
        plain_pending_q.push_back(t_block'(1));
        plain_pending_q.push_back(t_block'(1) << 63);
        queue_random(250);
        drain_pipeline();

        // all-ones key; high register written with excess bits set
        write_cfg(CFG_KEY_LOW, '1);
        write_cfg(CFG_KEY_HIGH, '1);
        plain_pending_q.push_back('0);
        plain_pending_q.push_back('1);
        plain_pending_q.push_back(64'h0123_4567_89ab_cdef);
        queue_random(250);
        drain_pipeline();

        // low half cleared, high half kept at its maximum
        write_cfg(CFG_KEY_LOW, '0);
        write_cfg(CFG_KEY_HIGH, 64'hdead_beef_cafe_ffff);
        plain_pending_q.push_back('0);
        plain_pending_q.push_back('1);
        queue_random(250);
        drain_pipeline();

        // random keys, sometimes only one half rewritten
        for (int ph = 0; ph < 5; ph++) begin
            case ($urandom_range(0, 2))
                0: write_cfg(CFG_KEY_LOW, {$urandom, $urandom});
                1: write_cfg(CFG_KEY_HIGH, {$urandom, $urandom});
                default: begin
                    write_cfg(CFG_KEY_HIGH, {$urandom, $urandom});
                    write_cfg(CFG_KEY_LOW, {$urandom, $urandom});
                end
            endcase
            queue_random(250);
            drain_pipeline();
        end

        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
